### hdl/svg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svg_pkg: shared types and constants of the safety supervisor velocity gate
// Holds field widths, operation and mode codes, register indexes and the
// entry type carried from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package svg_pkg;

   localparam int VEL_WIDTH   = 16;
   localparam int TICK_WIDTH  = 16;
   localparam int AXES        = 6;
   localparam int CFG_WIDTH   = 16;
   localparam int CSR_IDX_W   = 8;
   localparam int ACTION_W    = 3;
   localparam int SEVERITY_W  = 2;
   localparam int MODE_W      = 2;
   localparam int OP_W        = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Input tdata: severity, from_estop, healthy, six axes, padded to bytes.
   localparam int REQ_BITS    = SEVERITY_W + 2 + AXES * VEL_WIDTH;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_VEL_LSB = SEVERITY_W + 2;
   // Output tdata: mode, stop_latched, six axes, padded to bytes.
   localparam int RSP_BITS    = MODE_W + 1 + AXES * VEL_WIDTH;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_VEL_LSB = MODE_W + 1;

   localparam logic [ACTION_W-1:0] ACT_ANOMALY  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_RECOVERY = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_HEALTH   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_COMMAND  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_EMIT     = 3'd5;

   localparam logic [SEVERITY_W-1:0] SEV_WARNING  = 2'd1;
   localparam logic [SEVERITY_W-1:0] SEV_CRITICAL = 2'd2;

   localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
   localparam logic [OP_W-1:0] OP_WARNING  = 3'd1;
   localparam logic [OP_W-1:0] OP_CRITICAL = 3'd2;
   localparam logic [OP_W-1:0] OP_RECOVER  = 3'd3;
   localparam logic [OP_W-1:0] OP_HEALTH   = 3'd4;
   localparam logic [OP_W-1:0] OP_COMMAND  = 3'd5;
   localparam logic [OP_W-1:0] OP_TICK     = 3'd6;
   localparam logic [OP_W-1:0] OP_EMIT     = 3'd7;

   localparam logic [MODE_W-1:0] MODE_NORMAL          = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEGRADED        = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SAFE_STOP       = 2'd2;
   localparam logic [MODE_W-1:0] MODE_MANUAL_RECOVERY = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE   = 8'd1;

   localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [CFG_WIDTH-1:0] SCALE_RESET   = 16'd16384;

   typedef logic [AXES-1:0][VEL_WIDTH-1:0] svg_vel_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            from_estop;
      logic            healthy;
      svg_vel_type     vel;
   } svg_entry_type;

   typedef struct packed {
      logic                 valid;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_WIDTH-1:0] data;
   } svg_csr_type;

endpackage
`default_nettype wire

### hdl/svg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svg_front: input stage of the safety supervisor velocity gate
// Accepts request beats, decodes action and severity into one operation code
// and holds the entry until the queue takes it.
// ----------------------------------------------------------------------------
module svg_front
   import svg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0 up: severity, from_estop, healthy, lin_x_in, lin_y_in,
   // lin_z_in, ang_x_in, ang_y_in, ang_z_in, zero padding.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0 up: action.
   input  wire logic [ACTION_W-1:0]   req_tuser,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output svg_entry_type              push_entry
);

   logic          valid_ff;
   logic          valid_in;
   svg_entry_type entry_ff;
   svg_entry_type entry_in;
   logic          accept;

   assign req_tready = !valid_ff || push_ready;
   assign accept     = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      entry_in.from_estop = req_tdata[SEVERITY_W];
      entry_in.healthy    = req_tdata[SEVERITY_W+1];
      entry_in.vel        = req_tdata[REQ_VEL_LSB +: AXES*VEL_WIDTH];
      unique case (req_tuser)
         ACT_ANOMALY: begin
            if (req_tdata[SEVERITY_W-1:0] == SEV_CRITICAL) begin
               entry_in.op = OP_CRITICAL;
            end else if (req_tdata[SEVERITY_W-1:0] == SEV_WARNING) begin
               entry_in.op = OP_WARNING;
            end else begin
               entry_in.op = OP_NONE;
            end
         end
         ACT_RECOVERY: entry_in.op = OP_RECOVER;
         ACT_HEALTH:   entry_in.op = OP_HEALTH;
         ACT_COMMAND:  entry_in.op = OP_COMMAND;
         ACT_TICK:     entry_in.op = OP_TICK;
         ACT_EMIT:     entry_in.op = OP_EMIT;
         default:      entry_in.op = OP_NONE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule
`default_nettype wire

### hdl/svg_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svg_queue: short queue between front end and back end
// A small first-in first-out buffer of decoded entries so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module svg_queue
   import svg_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output logic                push_ready,
   input  wire svg_entry_type  push_entry,
   output logic                pop_valid,
   input  wire logic           pop_ready,
   output svg_entry_type       pop_entry
);

   svg_entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]         wr_ptr_ff;
   logic [QUEUE_AW-1:0]         wr_ptr_in;
   logic [QUEUE_AW-1:0]         rd_ptr_ff;
   logic [QUEUE_AW-1:0]         rd_ptr_in;
   logic [QUEUE_AW:0]           count_ff;
   logic [QUEUE_AW:0]           count_in;
   logic                        push;
   logic                        pop;

   assign push_ready = count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

### hdl/svg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svg_back: supervisor state machine and velocity gate
// Executes one queued operation per cycle while the response side keeps up,
// keeps mode, latch, health, command and degraded tick count, and drives the
// registered response beat.
module svg_back
   import svg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire svg_csr_type           csr,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire svg_entry_type         pop_entry,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser
);

   localparam int PROD_W = VEL_WIDTH + CFG_WIDTH + 1;
   localparam int Q_W    = PROD_W - 15;
   localparam int CMP_W  = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;

   function automatic logic [VEL_WIDTH-1:0] scale_sat(input logic [VEL_WIDTH-1:0] v,
                                                      input logic [CFG_WIDTH-1:0] s);
      logic signed [PROD_W-1:0] p;
      logic signed [Q_W-1:0]    q;
      logic [VEL_WIDTH-1:0]     r;
      p = $signed(v) * $signed({1'b0, s});
      q = $signed(p[PROD_W-1:15]);
      if (q > $signed({{(Q_W-VEL_WIDTH+1){1'b0}}, {(VEL_WIDTH-1){1'b1}}})) begin
         r = {1'b0, {(VEL_WIDTH-1){1'b1}}};
      end else if (q < $signed({{(Q_W-VEL_WIDTH+1){1'b1}}, {(VEL_WIDTH-1){1'b0}}})) begin
         r = {1'b1, {(VEL_WIDTH-1){1'b0}}};
      end else begin
         r = q[VEL_WIDTH-1:0];
      end
      return r;
   endfunction

   logic [CFG_WIDTH-1:0]  timeout_ff;
   logic [CFG_WIDTH-1:0]  scale_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic [MODE_W-1:0]     mode_in;
   logic                  estop_ff;
   logic                  estop_in;
   logic                  health_ff;
   logic                  health_in;
   svg_vel_type           cmd_ff;
   svg_vel_type           cmd_in;
   logic [TICK_WIDTH-1:0] ticks_ff;
   logic [TICK_WIDTH-1:0] ticks_in;
   logic [TICK_WIDTH-1:0] tick_inc;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [MODE_W-1:0]     rsp_mode_ff;
   logic                  rsp_stop_ff;
   logic                  rsp_drive_ff;
   svg_vel_type           rsp_vel_ff;
   logic                  drive_valid;
   svg_vel_type           drive;
   svg_vel_type           scaled;
   logic                  pop;

   assign pop_ready  = !rsp_valid_ff || rsp_tready;
   assign pop        = pop_valid && pop_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_drive_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_vel_ff, rsp_stop_ff, rsp_mode_ff});
   assign tick_inc   = (ticks_ff == {TICK_WIDTH{1'b1}}) ? ticks_ff : ticks_ff + 1'b1;

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         scaled[i] = scale_sat(cmd_ff[i], scale_ff);
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      estop_in    = estop_ff;
      health_in   = health_ff;
      cmd_in      = cmd_ff;
      ticks_in    = ticks_ff;
      drive_valid = 1'b0;
      drive       = '0;
      if (pop) begin
         case (pop_entry.op)
            OP_CRITICAL: begin
               if (pop_entry.from_estop) begin
                  estop_in = 1'b1;
               end
               mode_in = MODE_SAFE_STOP;
            end
            OP_WARNING: begin
               if (mode_ff == MODE_NORMAL) begin
                  mode_in = MODE_DEGRADED;
               end else if (mode_ff == MODE_DEGRADED) begin
                  mode_in = MODE_SAFE_STOP;
               end
            end
            OP_RECOVER: begin
               if (mode_ff == MODE_SAFE_STOP) begin
                  mode_in = MODE_MANUAL_RECOVERY;
               end else if (mode_ff == MODE_MANUAL_RECOVERY) begin
                  estop_in = 1'b0;
                  mode_in  = MODE_NORMAL;
               end
            end
            OP_HEALTH:  health_in = pop_entry.healthy;
            OP_COMMAND: cmd_in = pop_entry.vel;
            OP_TICK: begin
               if (mode_ff == MODE_DEGRADED) begin
                  ticks_in = tick_inc;
                  if (CMP_W'(tick_inc) >= CMP_W'(timeout_ff)) begin
                     mode_in = MODE_SAFE_STOP;
                  end
               end
            end
            OP_EMIT: begin
               drive_valid = 1'b1;
               unique case (mode_ff)
                  MODE_NORMAL:   drive = cmd_ff;
                  MODE_DEGRADED: drive = scaled;
                  default:       drive = (health_ff && !estop_ff) ? cmd_ff : '0;
               endcase
            end
            default: ;
         endcase
         if (mode_in != mode_ff) begin
            ticks_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         scale_ff     <= SCALE_RESET;
         mode_ff      <= MODE_NORMAL;
         estop_ff     <= 1'b0;
         health_ff    <= 1'b0;
         cmd_ff       <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.index == CSR_TIMEOUT) begin
            timeout_ff <= csr.data;
         end
         if (csr.valid && csr.index == CSR_SCALE) begin
            scale_ff <= csr.data;
         end
         mode_ff      <= mode_in;
         estop_ff     <= estop_in;
         health_ff    <= health_in;
         cmd_ff       <= cmd_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_mode_ff  <= mode_in;
         rsp_stop_ff  <= estop_in;
         rsp_drive_ff <= drive_valid;
         rsp_vel_ff   <= drive;
      end
   end

   a_latch_only_stopped: assert property (@(posedge clock) disable iff (reset)
      estop_ff |-> (mode_ff == MODE_SAFE_STOP || mode_ff == MODE_MANUAL_RECOVERY))
      else $error("Stop latch is set outside the stop modes.");

   a_ticks_only_degraded: assert property (@(posedge clock) disable iff (reset)
      (ticks_ff != '0) |-> (mode_ff == MODE_DEGRADED))
      else $error("Degraded tick count is nonzero outside DEGRADED.");

   a_mode_change_clears_ticks: assert property (@(posedge clock) disable iff (reset)
      (mode_in != mode_ff) |=> (ticks_ff == '0))
      else $error("Mode change did not clear the degraded tick count.");

endmodule
`default_nettype wire

### hdl/safety_supervisor_velocity_gate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// safety_supervisor_velocity_gate: four-mode safety supervisor with drive gate
// Every request beat produces exactly one response beat carrying the mode and
// stop latch after the step and, on an emit request, the gated six-axis drive
// command. One beat is accepted per clock cycle for as long as the response
// side keeps up. An accepted beat is held in the front register, moves into the
// two-entry queue and is then executed into the output register, which offers
// its response. Up to four beats are held inside while the response side
// stalls. The back end executes one operation per cycle while the response
// side keeps up, including the six parallel 16 by 17 bit scale multiplies of
// DEGRADED. The configuration port is always ready and must be written only
// while no request is in flight.
// ----------------------------------------------------------------------------
module safety_supervisor_velocity_gate
   import svg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Fields from bit 0 up: severity, from_estop, healthy, lin_x_in, lin_y_in,
   // lin_z_in, ang_x_in, ang_y_in, ang_z_in, zero padding.
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0 up: action.
   input  wire logic [ACTION_W-1:0]   req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Fields from bit 0 up: mode, stop_latched, lin_x_out, lin_y_out,
   // lin_z_out, ang_x_out, ang_y_out, ang_z_out, zero padding.
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // Fields from bit 0 up: drive_valid.
   output logic                       rsp_tuser,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_WIDTH-1:0]  csr_data
);

   logic          push_valid;
   logic          push_ready;
   svg_entry_type push_entry;
   logic          pop_valid;
   logic          pop_ready;
   svg_entry_type pop_entry;
   svg_csr_type   csr;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   svg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   svg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   svg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
